/* hw/rtl/stip_pkg.sv */
// ----------------------------------------------------------------------------
// stip_pkg
// Shared types and constants of the string to integer parser: character
// classes, radix codes, result status codes and queue sizing.
// ----------------------------------------------------------------------------
package stip_pkg;

  localparam int unsigned MaxStringLength = 65535;
  localparam logic [15:0] MaxPos         = 16'(MaxStringLength);

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef logic [5:0] base_t;
  typedef logic [5:0] digit_t;

  localparam base_t  BaseAuto    = 6'd0;
  localparam base_t  BaseInvalid = 6'd1;
  localparam base_t  BaseOctal   = 6'd8;
  localparam base_t  BaseDecimal = 6'd10;
  localparam base_t  BaseHex     = 6'd16;
  localparam base_t  BaseMax     = 6'd36;
  localparam digit_t DigitNone   = 6'd36;
  localparam digit_t LetterBias  = 6'd10;

  localparam logic [7:0] CharNul    = 8'h00;
  localparam logic [7:0] CharTab    = 8'h09;
  localparam logic [7:0] CharCr     = 8'h0d;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharPlus   = 8'h2b;
  localparam logic [7:0] CharMinus  = 8'h2d;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;
  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperZ = 8'h5a;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharLowerX = 8'h78;
  localparam logic [7:0] CharLowerZ = 8'h7a;

  localparam logic [63:0] LimitPos = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] LimitNeg = 64'h8000_0000_0000_0000;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusNoDigits = 2'd1,
    StatusOverflow = 2'd2,
    StatusBadBase  = 2'd3
  } status_e;

  typedef struct packed {
    logic   is_nul;
    logic   is_space;
    logic   is_minus;
    logic   is_plus;
    logic   is_zero;
    logic   is_x;
    digit_t digit;
  } char_class_t;

endpackage

/* hw/rtl/stip_classify.sv */
// ----------------------------------------------------------------------------
// stip_classify
// Front end decode: turns one string byte into its character class and
// digit value ahead of the queue.
// ----------------------------------------------------------------------------
module stip_classify (
  input  logic                 [7:0] character_i,
  output stip_pkg::char_class_t      class_o
);
  import stip_pkg::*;

  always_comb begin
    class_o          = '0;
    class_o.is_nul   = (character_i == CharNul);
    class_o.is_space = (character_i == CharSpace) ||
                       ((character_i >= CharTab) && (character_i <= CharCr));
    class_o.is_minus = (character_i == CharMinus);
    class_o.is_plus  = (character_i == CharPlus);
    class_o.is_zero  = (character_i == CharZero);
    class_o.is_x     = (character_i == CharLowerX);
    if ((character_i >= CharZero) && (character_i <= CharNine)) begin
      class_o.digit = 6'(character_i - CharZero);
    end else if ((character_i >= CharLowerA) && (character_i <= CharLowerZ)) begin
      class_o.digit = 6'(character_i - CharLowerA) + LetterBias;
    end else if ((character_i >= CharUpperA) && (character_i <= CharUpperZ)) begin
      class_o.digit = 6'(character_i - CharUpperA) + LetterBias;
    end else begin
      class_o.digit = DigitNone;
    end
  end

endmodule

/* hw/rtl/stip_queue.sv */
// ----------------------------------------------------------------------------
// stip_queue
// Short first-in first-out queue of classified characters between the
// front end and the execute stage.
// ----------------------------------------------------------------------------
module stip_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  output logic                  push_ready_o,
  input  stip_pkg::char_class_t push_data_i,
  output logic                  pop_valid_o,
  input  logic                  pop_ready_i,
  output stip_pkg::char_class_t pop_data_o
);
  import stip_pkg::*;

  char_class_t            mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0]   count_q, count_d;
  logic                   push, pop;

  assign push_ready_o = (count_q != QueueCntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* hw/rtl/stip_exec.sv */
// ----------------------------------------------------------------------------
// stip_exec
// Execute stage: parse state machine, multiply-add accumulator with
// saturation, and the result output register.
// ----------------------------------------------------------------------------
module stip_exec (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  stip_pkg::base_t       number_base_i,
  input  logic                  item_valid_i,
  output logic                  item_ready_o,
  input  stip_pkg::char_class_t item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed    [63:0] parsed_value_o,
  output logic           [15:0] end_offset_o,
  output logic            [1:0] status_o
);
  import stip_pkg::*;

  typedef enum logic [2:0] {
    PhWs     = 3'd0,
    PhSigned = 3'd1,
    PhZero   = 3'd2,
    PhHexX   = 3'd3,
    PhDigits = 3'd4,
    PhSkip   = 3'd5
  } phase_e;

  phase_e        phase_q, phase_d;
  logic [63:0]   acc_q, acc_d;
  logic          neg_q, neg_d;
  base_t         base_q, base_d;
  logic [15:0]   pos_q, pos_d;
  logic [15:0]   zpo_q, zpo_d;
  logic          ovf_q, ovf_d;

  logic          out_valid_q;
  logic [63:0]   value_q;
  logic [15:0]   offset_q;
  status_e       status_q;

  logic          pop;
  logic          emit;
  logic [63:0]   emit_value;
  logic [15:0]   emit_offset;
  status_e       emit_status;
  logic          tail;
  base_t         tail_base;
  logic          add;
  logic          finish;
  logic [69:0]   prod;
  logic [70:0]   sum;
  logic [63:0]   limit;
  logic          over;

  assign item_ready_o = !out_valid_q || out_ready_i;
  assign pop          = item_valid_i && item_ready_o;

  assign limit = neg_q ? LimitNeg : LimitPos;
  assign prod  = 70'(acc_q) * 70'(base_q);
  assign sum   = {1'b0, prod} + 71'(item_i.digit);
  assign over  = (sum > {7'b0, limit});

  always_comb begin
    phase_d     = phase_q;
    acc_d       = acc_q;
    neg_d       = neg_q;
    base_d      = base_q;
    pos_d       = pos_q;
    zpo_d       = zpo_q;
    ovf_d       = ovf_q;
    emit        = 1'b0;
    emit_value  = '0;
    emit_offset = '0;
    emit_status = StatusOk;
    tail        = 1'b0;
    tail_base   = base_q;
    add         = 1'b0;
    finish      = 1'b0;

    case (phase_q)
      PhSkip: begin
      end
      PhZero: begin
        if (item_i.is_x) begin
          phase_d = PhHexX;
        end else begin
          phase_d = PhDigits;
          if (item_i.digit < base_q) begin
            add = 1'b1;
          end else begin
            finish = 1'b1;
          end
        end
      end
      PhHexX: begin
        if (item_i.digit < BaseHex) begin
          base_d  = BaseHex;
          acc_d   = 64'(item_i.digit);
          phase_d = PhDigits;
        end else begin
          emit        = 1'b1;
          emit_offset = zpo_q + 16'd1;
        end
      end
      PhDigits: begin
        if (item_i.digit < base_q) begin
          add = 1'b1;
        end else begin
          finish = 1'b1;
        end
      end
      PhSigned: begin
        tail      = 1'b1;
        tail_base = base_q;
      end
      default: begin
        base_d = number_base_i;
        if (!(item_i.is_space && !item_i.is_nul)) begin
          if ((number_base_i == BaseInvalid) || (number_base_i > BaseMax)) begin
            emit        = 1'b1;
            emit_status = StatusBadBase;
          end else begin
            phase_d = PhSigned;
            if (item_i.is_minus || item_i.is_plus) begin
              neg_d = item_i.is_minus;
            end else begin
              tail      = 1'b1;
              tail_base = number_base_i;
            end
          end
        end
      end
    endcase

    if (tail) begin
      if ((tail_base == BaseAuto) && item_i.is_zero) begin
        base_d  = BaseOctal;
        zpo_d   = pos_q;
        acc_d   = '0;
        phase_d = PhZero;
      end else begin
        base_d = (tail_base == BaseAuto) ? BaseDecimal : tail_base;
        if (item_i.digit < base_d) begin
          acc_d   = 64'(item_i.digit);
          phase_d = PhDigits;
        end else begin
          emit        = 1'b1;
          emit_status = StatusNoDigits;
        end
      end
    end

    if (add && !ovf_q && (base_q != BaseAuto)) begin
      if (over) begin
        ovf_d = 1'b1;
        acc_d = limit;
      end else begin
        acc_d = sum[63:0];
      end
    end

    if (finish) begin
      emit        = 1'b1;
      emit_value  = neg_q ? (64'd0 - acc_q) : acc_q;
      emit_offset = pos_q;
      emit_status = ovf_q ? StatusOverflow : StatusOk;
    end

    if (emit) begin
      phase_d = PhSkip;
    end

    if (item_i.is_nul) begin
      phase_d = PhWs;
      acc_d   = '0;
      neg_d   = 1'b0;
      base_d  = BaseAuto;
      pos_d   = '0;
      zpo_d   = '0;
      ovf_d   = 1'b0;
    end else if (pos_q < MaxPos) begin
      pos_d = pos_q + 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhWs;
      acc_q       <= '0;
      neg_q       <= 1'b0;
      base_q      <= BaseAuto;
      pos_q       <= '0;
      zpo_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
        neg_q   <= neg_d;
        base_q  <= base_d;
        pos_q   <= pos_d;
        zpo_q   <= zpo_d;
        ovf_q   <= ovf_d;
      end
      if (pop && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && emit) begin
      value_q  <= emit_value;
      offset_q <= emit_offset;
      status_q <= emit_status;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign parsed_value_o = value_q;
  assign end_offset_o   = offset_q;
  assign status_o       = status_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhDigits) |-> ((base_q >= 6'd2) && (base_q <= BaseMax)))
    else $error("digit phase with unusable radix");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> ((phase_q == PhDigits) || (phase_q == PhSkip)))
    else $error("overflow flag outside digit or skip phase");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhDigits) |-> (acc_q <= limit))
    else $error("accumulator beyond saturation limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(pop))
    else $error("result raised without a consumed transaction");

endmodule

/* hw/rtl/string_to_integer_parser_core.sv */
// ----------------------------------------------------------------------------
// string_to_integer_parser_core
// Character-serial strtoll-style parser with radix register.
// ----------------------------------------------------------------------------
// One character is taken per clock cycle when the output side keeps up; a
// character is decoded on entry, held in a two-entry queue and consumed by the
// execute stage, which registers out_valid_o when it consumes the character that
// ends the number. The throughput limit is the combinational multiply-add by
// the radix in the execute stage; a stalled result holds the execute stage and
// lets the queue fill. Write the radix register only between strings, with no
// characters outstanding.
module string_to_integer_parser_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic        [5:0]  cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic        [7:0]  character_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [63:0] parsed_value_o,
  output logic        [15:0] end_offset_o,
  output logic        [1:0]  status_o
);
  import stip_pkg::*;

  base_t       number_base_q;
  char_class_t in_class;
  char_class_t q_class;
  logic        q_valid;
  logic        q_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      number_base_q <= BaseDecimal;
    end else if (cfg_we_i) begin
      number_base_q <= cfg_wdata_i;
    end
  end

  stip_classify u_classify (
    .character_i (character_i),
    .class_o     (in_class)
  );

  stip_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_data_i  (in_class),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_class)
  );

  stip_exec u_exec (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .number_base_i  (number_base_q),
    .item_valid_i   (q_valid),
    .item_ready_o   (q_ready),
    .item_i         (q_class),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .parsed_value_o (parsed_value_o),
    .end_offset_o   (end_offset_o),
    .status_o       (status_o)
  );

endmodule

/* test/tb_string_to_integer_parser_core.sv */
// ----------------------------------------------------------------------------
// tb_string_to_integer_parser_core
// Self-checking bench for the character-serial string to integer parser. A
// queue of strings feeds a valid/ready driver with random idle bursts on both
// channels. Each accepted character steps a local parser model, and every
// result transaction is checked against the oldest predicted result. The
// radix register is rewritten between groups of strings, covering
// autodetect and the extreme and invalid radices.
// ----------------------------------------------------------------------------
module tb_string_to_integer_parser_core;
  import stip_pkg::*;

  localparam int unsigned RandomItems = 1950;
  localparam int unsigned GroupItems  = 160;
  localparam int unsigned SettleWait  = 8;
  localparam int unsigned DrainWait   = 12;
  localparam int unsigned CycleLimit  = 1500000;

  localparam base_t FirstRadices [9] = '{BaseAuto, 6'd2, BaseMax, BaseHex, BaseOctal,
                                         BaseInvalid, 6'd63, 6'd37, 6'd35};

  typedef enum logic [2:0] {
    PhaseLead,
    PhaseSigned,
    PhaseZero,
    PhaseHexX,
    PhaseDigits,
    PhaseSkip
  } parse_phase_e;

  typedef struct {
    logic signed [63:0] value;
    logic        [15:0] offset;
    status_e            status;
  } parsed_result_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic        [5:0]  cfg_wdata_i = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic        [7:0]  character_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [63:0] parsed_value_o;
  logic        [15:0] end_offset_o;
  logic        [1:0]  status_o;

  string_to_integer_parser_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .character_i    (character_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .parsed_value_o (parsed_value_o),
    .end_offset_o   (end_offset_o),
    .status_o       (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [7:0]     pending_chars [$];
  parsed_result_t expected_results [$];

  int unsigned chars_queued    = 0;
  int unsigned chars_accepted  = 0;
  int unsigned strings_queued  = 0;
  int unsigned results_checked = 0;
  int unsigned radix_writes    = 0;
  int unsigned err_count       = 0;
  int unsigned cycle_count     = 0;
  int unsigned idle_odds       = 4;
  int unsigned in_gap          = 0;
  int unsigned out_gap         = 0;
  logic        in_taken        = 1'b0;

  parse_phase_e ps_phase    = PhaseLead;
  logic [63:0]  ps_acc      = '0;
  logic         ps_neg      = 1'b0;
  base_t        ps_base     = BaseAuto;
  logic [15:0]  ps_pos      = '0;
  logic [15:0]  ps_zero_pos = '0;
  logic         ps_ovf      = 1'b0;
  base_t        radix_setting = BaseDecimal;

  function automatic digit_t digit_value(logic [7:0] c);
    if (c >= CharZero && c <= CharNine) return digit_t'(c - CharZero);
    if (c >= CharLowerA && c <= CharLowerZ) return digit_t'(c - CharLowerA) + LetterBias;
    if (c >= CharUpperA && c <= CharUpperZ) return digit_t'(c - CharUpperA) + LetterBias;
    return DigitNone;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c == CharSpace || (c >= CharTab && c <= CharCr);
  endfunction

  task automatic clear_parse();
    ps_phase    = PhaseLead;
    ps_acc      = '0;
    ps_neg      = 1'b0;
    ps_base     = BaseAuto;
    ps_pos      = '0;
    ps_zero_pos = '0;
    ps_ovf      = 1'b0;
  endtask

  task automatic post_result(logic [63:0] v, logic [15:0] off, status_e st);
    parsed_result_t r;
    r.value  = v;
    r.offset = off;
    r.status = st;
    expected_results.push_back(r);
    ps_phase = PhaseSkip;
  endtask

  task automatic post_number();
    post_result(ps_neg ? -ps_acc : ps_acc, ps_pos, ps_ovf ? StatusOverflow : StatusOk);
  endtask

  task automatic accumulate(digit_t d);
    logic [63:0] limit;
    limit = ps_neg ? LimitNeg : LimitPos;
    if (ps_ovf || ps_base == BaseAuto) return;
    if (ps_acc > (limit - 64'(d)) / 64'(ps_base)) begin
      ps_ovf = 1'b1;
      ps_acc = limit;
    end else begin
      ps_acc = ps_acc * 64'(ps_base) + 64'(d);
    end
  endtask

  task automatic take_first(logic [7:0] c, digit_t d);
    if (ps_base == BaseAuto && c == CharZero) begin
      ps_base     = BaseOctal;
      ps_zero_pos = ps_pos;
      ps_acc      = '0;
      ps_phase    = PhaseZero;
    end else begin
      if (ps_base == BaseAuto) ps_base = BaseDecimal;
      if (d < ps_base) begin
        ps_acc   = 64'(d);
        ps_phase = PhaseDigits;
      end else begin
        post_result('0, '0, StatusNoDigits);
      end
    end
  endtask

  task automatic parse_char(logic [7:0] c);
    digit_t d;
    d = digit_value(c);
    case (ps_phase)
      PhaseSkip: begin
      end
      PhaseZero: begin
        if (c == CharLowerX) begin
          ps_phase = PhaseHexX;
        end else begin
          ps_phase = PhaseDigits;
          if (d < ps_base) accumulate(d);
          else post_number();
        end
      end
      PhaseHexX: begin
        if (d < BaseHex) begin
          ps_base  = BaseHex;
          ps_acc   = 64'(d);
          ps_phase = PhaseDigits;
        end else begin
          post_result('0, ps_zero_pos + 16'd1, StatusOk);
        end
      end
      PhaseDigits: begin
        if (d < ps_base) accumulate(d);
        else post_number();
      end
      PhaseSigned: take_first(c, d);
      default: begin
        ps_base = radix_setting;
        if (!is_blank(c)) begin
          if (ps_base == BaseInvalid || ps_base > BaseMax) begin
            post_result('0, '0, StatusBadBase);
          end else begin
            ps_phase = PhaseSigned;
            if (c == CharMinus || c == CharPlus) ps_neg = (c == CharMinus);
            else take_first(c, d);
          end
        end
      end
    endcase
    if (c == CharNul) clear_parse();
    else if (ps_pos < MaxPos) ps_pos++;
  endtask

  task automatic queue_char(logic [7:0] c);
    pending_chars.push_back(c);
    chars_queued++;
    if (c == CharNul) strings_queued++;
  endtask

  task automatic queue_string(string s);
    for (int i = 0; i < s.len(); i++) queue_char(8'(s[i]));
    queue_char(CharNul);
  endtask

  task automatic queue_random_string();
    int unsigned kind;
    int unsigned n;
    int unsigned dv;
    base_t       gen_base;
    logic [7:0]  c;
    kind = $urandom_range(0, 9);
    if (kind >= 8) begin
      repeat ($urandom_range(0, 8)) queue_char(8'($urandom_range(1, 255)));
    end else begin
      gen_base = (radix_setting == BaseInvalid || radix_setting > BaseMax) ?
                 BaseDecimal : radix_setting;
      repeat ($urandom_range(0, 3)) begin
        c = $urandom_range(0, 1) ? CharSpace : CharTab + 8'($urandom_range(0, 4));
        queue_char(c);
      end
      case ($urandom_range(0, 2))
        0: queue_char(CharMinus);
        1: queue_char(CharPlus);
        default: begin
        end
      endcase
      if (gen_base == BaseAuto) begin
        case ($urandom_range(0, 2))
          0: begin
            queue_char(CharZero);
            queue_char(CharLowerX);
            gen_base = BaseHex;
          end
          1: begin
            queue_char(CharZero);
            gen_base = BaseOctal;
          end
          default: gen_base = BaseDecimal;
        endcase
      end
      if (kind == 7) n = 0;
      else if ($urandom_range(0, 5) == 0) n = $urandom_range(10, 70);
      else n = $urandom_range(1, 6);
      repeat (n) begin
        dv = $urandom_range(0, int'(gen_base) - 1);
        if (dv < 10) c = CharZero + 8'(dv);
        else c = ($urandom_range(0, 1) ? CharLowerA : CharUpperA) + 8'(dv - 10);
        queue_char(c);
      end
      if ($urandom_range(0, 2) != 0) begin
        do c = 8'($urandom_range(1, 255)); while (digit_value(c) < gen_base);
        queue_char(c);
        repeat ($urandom_range(0, 3)) queue_char(8'($urandom_range(1, 255)));
      end
    end
    queue_char(CharNul);
  endtask

  task automatic wait_drained();
    while (chars_accepted != chars_queued || expected_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic set_radix(base_t v);
    wait_drained();
    repeat (SettleWait) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i      <= 1'b1;
    cfg_wdata_i   <= v;
    radix_setting = v;
    radix_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // drive characters and output ready; hold payload until the transaction completes
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_chars.size() != 0 && idle_odds != 0 &&
                     $urandom_range(1, idle_odds) == 1) begin
          in_gap = $urandom_range(0, 2);
          in_valid_i <= 1'b0;
        end else if (pending_chars.size() != 0) begin
          in_valid_i  <= 1'b1;
          character_i <= pending_chars.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready_i <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        out_gap = $urandom_range(0, 2);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    parsed_result_t want;
    in_taken = rst_ni && in_valid_i && in_ready_o;
    if (in_taken) begin
      parse_char(character_i);
      chars_accepted++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result: expected none, actual value %0d offset %0d status %0d",
                 $time, parsed_value_o, end_offset_o, status_o);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (parsed_value_o !== want.value) begin
          err_count++;
          $display("%0t: value mismatch: expected %0d, actual %0d",
                   $time, want.value, parsed_value_o);
        end
        if (end_offset_o !== want.offset) begin
          err_count++;
          $display("%0t: end offset mismatch: expected %0d, actual %0d",
                   $time, want.offset, end_offset_o);
        end
        if (status_o !== want.status) begin
          err_count++;
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, status_o);
        end
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("cycle limit of %0d reached at %0t", CycleLimit, $time);
    $display("tb_string_to_integer_parser_core: errors");
    $finish;
  end

  initial begin
    int unsigned random_start;
    int unsigned group_end;
    int unsigned group_idx;
    base_t       pick;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset radix: negative zero, empty string, sign without digits, top byte
    queue_char(CharMinus);
    queue_char(CharZero);
    queue_char(8'hff);
    queue_char(CharNul);
    queue_char(CharNul);
    queue_string(" +x");

    set_radix(BaseAuto);
    queue_string("0x");
    queue_string("0xf");

    set_radix(BaseMax);
    queue_string("zzzzzzzzzzzzz");

    set_radix(BaseInvalid);
    queue_string(" 5");

    random_start = chars_queued;
    group_idx    = 0;
    while (chars_queued - random_start < RandomItems) begin
      if (group_idx < $size(FirstRadices)) begin
        pick = FirstRadices[group_idx];
      end else if ($urandom_range(0, 3) == 0) begin
        pick = 6'($urandom_range(0, 63));
      end else begin
        pick = ($urandom_range(0, 5) == 0) ? BaseAuto : 6'($urandom_range(2, 36));
      end
      set_radix(pick);
      if (chars_queued - random_start > RandomItems * 4 / 5) idle_odds = 0;
      else idle_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 8);
      group_end = chars_queued + GroupItems;
      while (chars_queued < group_end) queue_random_string();
      group_idx++;
    end

    wait_drained();
    repeat (DrainWait) @(posedge clk_i);

    $display("%0d strings, %0d characters, %0d results checked over %0d radix writes",
             strings_queued, chars_accepted, results_checked, radix_writes);
    $display("covered blanks, signs, radix autodetect, overflow and invalid radix");
    if (err_count == 0 && expected_results.size() == 0) begin
      $display("tb_string_to_integer_parser_core: clean");
    end else begin
      $display("tb_string_to_integer_parser_core: errors");
    end
    $finish;
  end

endmodule
